// File: hdl/glm_pkg.sv
`default_nettype none
package glm_pkg;

  localparam int MAX_WIDTH  = 256;
  localparam int MAX_HEIGHT = 256;
  localparam int DEPTH      = MAX_WIDTH * MAX_HEIGHT;
  localparam int ADDR_W     = $clog2(DEPTH);

  // shared serial divider sizes
  localparam int DIVD_W = 25;
  localparam int DIVS_W = 18;

  localparam logic [2:0] REG_ORIGIN_X    = 3'd0;
  localparam logic [2:0] REG_ORIGIN_Y    = 3'd1;
  localparam logic [2:0] REG_CELL_STEP   = 3'd2;
  localparam logic [2:0] REG_GRID_WIDTH  = 3'd3;
  localparam logic [2:0] REG_GRID_HEIGHT = 3'd4;

  localparam logic OP_DRAW = 1'b0;
  localparam logic OP_READ = 1'b1;

  typedef enum logic [4:0] {
    S_CLEAR,
    S_IDLE,
    S_READ,
    S_READ_WAIT,
    S_DELTA,
    S_SQX,
    S_SQY,
    S_ROOT,
    S_NDIV,
    S_NWAIT,
    S_SDIV,
    S_SWAIT,
    S_PT,
    S_ORG,
    S_CDIV,
    S_CWAIT,
    S_MARK,
    S_DONE
  } state_t;

endpackage
`default_nettype wire

// File: hdl/glm_div.sv
`default_nettype none
module glm_div (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       start,
  input  wire logic [glm_pkg::DIVD_W-1:0] dividend,
  input  wire logic [glm_pkg::DIVS_W-1:0] divisor,
  output logic                            done,
  output logic [glm_pkg::DIVD_W-1:0]      quotient,
  output logic [glm_pkg::DIVS_W-1:0]      remainder
);

  localparam int CNT_W = $clog2(glm_pkg::DIVD_W);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [glm_pkg::DIVS_W-1:0] dvs;
  logic [glm_pkg::DIVS_W:0]   trial;
  logic                       fits;

  // one quotient bit per cycle, restoring
  assign trial = {remainder, quotient[glm_pkg::DIVD_W-1]};
  assign fits  = trial >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(glm_pkg::DIVD_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quotient  <= dividend;
      remainder <= '0;
      dvs       <= divisor;
    end else if (busy) begin
      if (fits) begin
        remainder <= glm_pkg::DIVS_W'(trial - {1'b0, dvs});
      end else begin
        remainder <= trial[glm_pkg::DIVS_W-1:0];
      end
      quotient <= {quotient[glm_pkg::DIVD_W-2:0], fits};
    end
  end

endmodule
`default_nettype wire

// File: hdl/grid_line_marker.sv
`default_nettype none
// grid_line_marker: marks grid cells along a segment in an occupancy bitmap
// and reads single cells back.
// s_axis carries one item per transfer: tuser is the op (0 draw, 1 read),
// tdata the endpoints and the query cell. m_axis returns one result per item.
// cfg writes the five grid registers by index; the user must change them only
// while the block is idle; the block itself does not enforce it.
// after reset the bitmap is cleared one cell per cycle, all 65536 cells, with
// s_axis_tready low; cfg writes are taken during that pass.
// a read item passes S_READ, S_READ_WAIT and S_DONE; an off-grid query skips
// S_READ_WAIT. a draw item takes setup states for the difference, its
// magnitude and the squares, 25 square root steps, two divisions for the
// point count and the step, then per point the states S_PT, S_ORG, S_CDIV,
// S_CWAIT and S_MARK: each point goes through the 25 step serial divider for
// its column and row, so cost grows with the segment length over the cell
// size. S_DONE then hands the result to the output register.
// one item is processed at a time; the next item is taken as soon as the
// result sits in the output register, and a stalled m_axis holds the result
// there and the next item waits until that register is free.
module grid_line_marker (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // start_x, start_y, end_x, end_y, query_column, query_row
  input  wire logic [111:0] s_axis_tdata,
  // op
  input  wire logic         s_axis_tuser,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // status, cell_value, cells_marked
  output logic [15:0]       m_axis_tdata,
  input  wire logic         cfg_valid,
  output logic              cfg_ready,
  input  wire logic [2:0]   cfg_index,
  input  wire logic [15:0]  cfg_data
);

  localparam int AW = glm_pkg::ADDR_W;
  localparam int DW = glm_pkg::DIVD_W;
  localparam int SW = glm_pkg::DIVS_W;

  glm_pkg::state_t state, state_next;

  logic signed [15:0] origin_x, origin_y;
  logic [7:0]         cell_step;
  logic [8:0]         grid_width, grid_height;
  logic [7:0]         step_eff;

  logic               op;
  logic signed [23:0] sx, sy, ex, ey;
  logic [7:0]         qc, qr;

  logic signed [24:0] dx, dy;
  logic [23:0]        adx, ady;
  logic               negx, negy;
  logic [47:0]        sqx, sqy;
  logic [49:0]        rad, rad_sum;
  logic [24:0]        root;
  logic [28:0]        rrem;
  logic [28:0]        rrem_sh, trial;
  logic [4:0]         cnt;

  logic [17:0]        n, idx;
  logic [24:0]        qdx, qdy, qa, qb;
  logic [17:0]        rdx, rdy;
  logic [18:0]        ra, rb, ra_sum, rb_sum;
  logic               at_end;

  logic signed [24:0] pxr, pyr, offx, offy;
  logic signed [16:0] ixs, iys;
  logic signed [17:0] vx, vy;
  logic               offneg_x, offneg_y;
  logic               off_grid, query_off;

  logic [9:0]         marked;
  logic               res_status, res_value;

  logic               div_start;
  logic [DW-1:0]      dvd_x, dvd_y, quo_x, quo_y;
  logic [SW-1:0]      dvs_x, dvs_y, rem_x, rem_y;
  logic               done_x, done_y;

  logic               occ [glm_pkg::DEPTH];
  logic               mem_we, mem_wd, mem_re, mem_rd;
  logic [AW-1:0]      mem_wa, mem_ra, clr_addr;
  logic               in_xfer, out_free;

  assign step_eff  = (cell_step == 8'd0) ? 8'd1 : cell_step;
  assign cfg_ready = 1'b1;
  assign in_xfer   = s_axis_tvalid && s_axis_tready;
  assign out_free  = !m_axis_tvalid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      origin_x    <= '0;
      origin_y    <= '0;
      cell_step   <= 8'd1;
      grid_width  <= 9'd256;
      grid_height <= 9'd256;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        glm_pkg::REG_ORIGIN_X:    origin_x    <= $signed(cfg_data);
        glm_pkg::REG_ORIGIN_Y:    origin_y    <= $signed(cfg_data);
        glm_pkg::REG_CELL_STEP:   cell_step   <= cfg_data[7:0];
        glm_pkg::REG_GRID_WIDTH:  grid_width  <= cfg_data[8:0];
        glm_pkg::REG_GRID_HEIGHT: grid_height <= cfg_data[8:0];
        default: ;
      endcase
    end
  end

  // square root step: two radicand bits per cycle
  assign rad_sum = {2'b00, sqx} + {2'b00, sqy};
  assign rrem_sh = {rrem[26:0], rad[49:48]};
  assign trial   = {2'b00, root, 2'b01};

  assign ra_sum = ra + {1'b0, rdx};
  assign rb_sum = rb + {1'b0, rdy};

  assign offx = negx ? -$signed(qa) : $signed(qa);
  assign offy = negy ? -$signed(qb) : $signed(qb);

  // truncate toward zero on the Q16.8 point
  assign ixs = 17'(pxr >>> 8) + 17'((pxr < 0 && pxr[7:0] != 8'd0) ? 1 : 0);
  assign iys = 17'(pyr >>> 8) + 17'((pyr < 0 && pyr[7:0] != 8'd0) ? 1 : 0);

  assign query_off = ({1'b0, qc} >= grid_width) || (32'(qc) >= glm_pkg::MAX_WIDTH) ||
                     ({1'b0, qr} >= grid_height) || (32'(qr) >= glm_pkg::MAX_HEIGHT);

  assign off_grid = offneg_x || offneg_y ||
                    (quo_x >= DW'(grid_width)) || (quo_x >= DW'(glm_pkg::MAX_WIDTH)) ||
                    (quo_y >= DW'(grid_height)) || (quo_y >= DW'(glm_pkg::MAX_HEIGHT));

  always_comb begin
    dvd_x = {1'b0, adx};
    dvd_y = {1'b0, ady};
    dvs_x = n;
    dvs_y = n;
    unique case (state)
      glm_pkg::S_NDIV: begin
        dvd_x = DW'(root[24:8]);
        dvs_x = SW'(step_eff);
      end
      glm_pkg::S_CDIV: begin
        dvd_x = (vx < 0) ? '0 : DW'(vx);
        dvd_y = (vy < 0) ? '0 : DW'(vy);
        dvs_x = SW'(step_eff);
        dvs_y = SW'(step_eff);
      end
      default: ;
    endcase
  end

  glm_div u_div_x (
    .clk(clk), .rst(rst), .start(div_start), .dividend(dvd_x), .divisor(dvs_x),
    .done(done_x), .quotient(quo_x), .remainder(rem_x)
  );

  glm_div u_div_y (
    .clk(clk), .rst(rst), .start(div_start), .dividend(dvd_y), .divisor(dvs_y),
    .done(done_y), .quotient(quo_y), .remainder(rem_y)
  );

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      glm_pkg::S_CLEAR:
        if (clr_addr == AW'(glm_pkg::DEPTH - 1)) state_next = glm_pkg::S_IDLE;
      glm_pkg::S_IDLE:
        if (in_xfer) begin
          state_next = (s_axis_tuser == glm_pkg::OP_READ) ? glm_pkg::S_READ
                                                          : glm_pkg::S_DELTA;
        end
      glm_pkg::S_READ:
        state_next = query_off ? glm_pkg::S_DONE : glm_pkg::S_READ_WAIT;
      glm_pkg::S_READ_WAIT: state_next = glm_pkg::S_DONE;
      glm_pkg::S_DELTA:     state_next = glm_pkg::S_SQX;
      glm_pkg::S_SQX:       state_next = glm_pkg::S_SQY;
      glm_pkg::S_SQY:       state_next = glm_pkg::S_ROOT;
      glm_pkg::S_ROOT:
        if (cnt == 5'd24) state_next = glm_pkg::S_NDIV;
      glm_pkg::S_NDIV:      state_next = glm_pkg::S_NWAIT;
      glm_pkg::S_NWAIT:
        if (done_x) state_next = glm_pkg::S_SDIV;
      glm_pkg::S_SDIV:      state_next = glm_pkg::S_SWAIT;
      glm_pkg::S_SWAIT:
        if (done_x) state_next = glm_pkg::S_PT;
      glm_pkg::S_PT:        state_next = glm_pkg::S_ORG;
      glm_pkg::S_ORG:       state_next = glm_pkg::S_CDIV;
      glm_pkg::S_CDIV:      state_next = glm_pkg::S_CWAIT;
      glm_pkg::S_CWAIT:
        if (done_x) state_next = off_grid ? glm_pkg::S_DONE : glm_pkg::S_MARK;
      glm_pkg::S_MARK:
        state_next = at_end ? glm_pkg::S_DONE : glm_pkg::S_PT;
      glm_pkg::S_DONE:
        if (out_free) state_next = glm_pkg::S_IDLE;
      default: state_next = glm_pkg::S_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    s_axis_tready = 1'b0;
    div_start     = 1'b0;
    mem_we        = 1'b0;
    mem_wd        = 1'b0;
    mem_wa        = clr_addr;
    mem_re        = 1'b0;
    mem_ra        = AW'(AW'(qr) * AW'(glm_pkg::MAX_WIDTH) + AW'(qc));
    unique case (state)
      glm_pkg::S_CLEAR: mem_we = 1'b1;
      glm_pkg::S_IDLE:  s_axis_tready = 1'b1;
      glm_pkg::S_READ:  mem_re = !query_off;
      glm_pkg::S_NDIV, glm_pkg::S_SDIV, glm_pkg::S_CDIV: div_start = 1'b1;
      glm_pkg::S_MARK: begin
        mem_we = 1'b1;
        mem_wd = 1'b1;
        mem_wa = AW'(AW'(quo_y) * AW'(glm_pkg::MAX_WIDTH) + AW'(quo_x));
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) occ[mem_wa] <= mem_wd;
    if (mem_re) mem_rd <= occ[mem_ra];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= glm_pkg::S_CLEAR;
      clr_addr      <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == glm_pkg::S_CLEAR) clr_addr <= clr_addr + 1'b1;
      if (state == glm_pkg::S_DONE && out_free) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == glm_pkg::S_DONE && out_free) begin
      m_axis_tdata <= {4'd0, marked, res_value, res_status};
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    unique case (state)
      glm_pkg::S_IDLE:
        if (in_xfer) begin
          op         <= s_axis_tuser;
          sx         <= $signed(s_axis_tdata[23:0]);
          sy         <= $signed(s_axis_tdata[47:24]);
          ex         <= $signed(s_axis_tdata[71:48]);
          ey         <= $signed(s_axis_tdata[95:72]);
          qc         <= s_axis_tdata[103:96];
          qr         <= s_axis_tdata[111:104];
          marked     <= '0;
          res_status <= 1'b0;
          res_value  <= 1'b0;
        end
      glm_pkg::S_READ:
        if (query_off) res_status <= 1'b1;
      glm_pkg::S_READ_WAIT: res_value <= mem_rd;
      glm_pkg::S_DELTA: begin
        dx <= 25'(ex) - 25'(sx);
        dy <= 25'(ey) - 25'(sy);
      end
      glm_pkg::S_SQX: begin
        negx <= dx < 0;
        negy <= dy < 0;
        adx  <= 24'(dx < 0 ? -dx : dx);
        ady  <= 24'(dy < 0 ? -dy : dy);
      end
      glm_pkg::S_SQY: begin
        sqx  <= 48'(adx) * 48'(adx);
        sqy  <= 48'(ady) * 48'(ady);
        root <= '0;
        rrem <= '0;
        cnt  <= '0;
      end
      glm_pkg::S_ROOT: begin
        if (cnt == 5'd0) begin
          // first digit taken straight from the fresh sum
          rad  <= rad_sum << 2;
          if ({27'd0, rad_sum[49:48]} >= trial) begin
            rrem <= {27'd0, rad_sum[49:48]} - trial;
            root <= {root[23:0], 1'b1};
          end else begin
            rrem <= {27'd0, rad_sum[49:48]};
            root <= {root[23:0], 1'b0};
          end
        end else begin
          rad <= rad << 2;
          if (rrem_sh >= trial) begin
            rrem <= rrem_sh - trial;
            root <= {root[23:0], 1'b1};
          end else begin
            rrem <= rrem_sh;
            root <= {root[23:0], 1'b0};
          end
        end
        cnt <= cnt + 1'b1;
      end
      glm_pkg::S_NWAIT:
        if (done_x) n <= 18'(quo_x) + 18'd1;
      glm_pkg::S_SWAIT:
        if (done_x) begin
          qdx    <= quo_x;
          qdy    <= quo_y;
          rdx    <= rem_x;
          rdy    <= rem_y;
          qa     <= '0;
          qb     <= '0;
          ra     <= '0;
          rb     <= '0;
          idx    <= '0;
          at_end <= 1'b0;
        end
      glm_pkg::S_PT: begin
        pxr <= at_end ? 25'(ex) : 25'(sx) + offx;
        pyr <= at_end ? 25'(ey) : 25'(sy) + offy;
      end
      glm_pkg::S_ORG: begin
        vx <= 18'(ixs) - 18'(origin_x);
        vy <= 18'(iys) - 18'(origin_y);
      end
      glm_pkg::S_CDIV: begin
        // a small negative offset still truncates into column or row zero
        offneg_x <= (vx < 0) && ($signed({vx[17], vx}) + $signed({11'd0, step_eff}) <= 0);
        offneg_y <= (vy < 0) && ($signed({vy[17], vy}) + $signed({11'd0, step_eff}) <= 0);
      end
      glm_pkg::S_CWAIT:
        if (done_x && off_grid) res_status <= 1'b1;
      glm_pkg::S_MARK: begin
        if (marked != 10'd1023) marked <= marked + 1'b1;
        if (!at_end) begin
          idx <= idx + 1'b1;
          if (idx + 1'b1 == n) begin
            at_end <= 1'b1;
          end else if (ra_sum >= {1'b0, n}) begin
            ra <= ra_sum - {1'b0, n};
            qa <= qa + qdx + 1'b1;
          end else begin
            ra <= ra_sum;
            qa <= qa + qdx;
          end
          if (idx + 1'b1 != n) begin
            if (rb_sum >= {1'b0, n}) begin
              rb <= rb_sum - {1'b0, n};
              qb <= qb + qdy + 1'b1;
            end else begin
              rb <= rb_sum;
              qb <= qb + qdy;
            end
          end
        end
      end
      default: ;
    endcase
  end

`ifndef SYNTHESIS
  a_no_input_while_clearing: assert property (@(posedge clk) disable iff (rst)
    (state == glm_pkg::S_CLEAR) |-> !s_axis_tready)
    else $error("input taken during clearing pass");

  a_read_has_no_count: assert property (@(posedge clk) disable iff (rst)
    (state == glm_pkg::S_DONE && op == glm_pkg::OP_READ) |-> (marked == 10'd0))
    else $error("read item carries a mark count");

  a_dividers_in_step: assert property (@(posedge clk) disable iff (rst)
    done_x == done_y)
    else $error("column and row dividers out of step");

  a_mark_on_grid: assert property (@(posedge clk) disable iff (rst)
    (state == glm_pkg::S_MARK) |-> $past(!off_grid))
    else $error("mark issued for an off-grid point");
`endif

endmodule
`default_nettype wire

// File: dv/tb.sv
`timescale 1ns / 100ps
module tb;

  localparam int CYCLE_LIMIT = 4_000_000;
  localparam int SETTLE      = 200;
  // an index past the last register, ignored by the block
  localparam logic [2:0] REG_NONE = 3'd7;

  typedef struct packed {
    logic       status;
    logic       cell_value;
    logic [9:0] cells_marked;
  } cell_result_t;

  class marker_scoreboard;
    bit           occ[glm_pkg::DEPTH];
    longint       org_x, org_y;
    int unsigned  step, width, height;
    cell_result_t due[$];
    int           errors;

    function new();
      org_x = 0; org_y = 0; step = 1; width = 256; height = 256;
    endfunction

    task report(string what, int unsigned got, int unsigned want);
      errors++;
      $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    endtask

    function void set_reg(logic [2:0] idx, logic [15:0] val);
      case (idx)
        glm_pkg::REG_ORIGIN_X:    org_x = longint'($signed(val));
        glm_pkg::REG_ORIGIN_Y:    org_y = longint'($signed(val));
        glm_pkg::REG_CELL_STEP:   step = val[7:0];
        glm_pkg::REG_GRID_WIDTH:  width = val[8:0];
        glm_pkg::REG_GRID_HEIGHT: height = val[8:0];
        default: ;
      endcase
    endfunction

    function int unsigned eff_step();
      return (step == 0) ? 1 : step;
    endfunction
    function longint eff_w();
      return (width > glm_pkg::MAX_WIDTH) ? glm_pkg::MAX_WIDTH : width;
    endfunction
    function longint eff_h();
      return (height > glm_pkg::MAX_HEIGHT) ? glm_pkg::MAX_HEIGHT : height;
    endfunction

    function longint unsigned int_root(longint unsigned v);
      longint unsigned res, bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv >>= 2;
      while (bitv != 0) begin
        if (v >= res + bitv) begin
          v -= res + bitv;
          res = (res >> 1) + bitv;
        end else begin
          res >>= 1;
        end
        bitv >>= 2;
      end
      return res;
    endfunction

    // marks the cell under a Q16.8 point, 0 if off the grid
    function bit mark_cell(longint px, longint py);
      longint st, col, row;
      st = eff_step();
      col = (px / 256 - org_x) / st;
      row = (py / 256 - org_y) / st;
      if (col < 0 || row < 0 || col >= eff_w() || row >= eff_h()) return 0;
      occ[row * glm_pkg::MAX_WIDTH + col] = 1;
      return 1;
    endfunction

    function void note_item(logic op, logic [111:0] d);
      cell_result_t r;
      longint sx, sy, ex, ey, dx, dy, n, i, c, q;
      longint unsigned adx, ady, root_len;
      bit ok;
      r = '0;
      if (op == glm_pkg::OP_READ) begin
        c = d[103:96];
        q = d[111:104];
        if (c >= eff_w() || q >= eff_h()) r.status = 1;
        else r.cell_value = occ[q * glm_pkg::MAX_WIDTH + c];
      end else begin
        sx = longint'($signed(d[23:0]));
        sy = longint'($signed(d[47:24]));
        ex = longint'($signed(d[71:48]));
        ey = longint'($signed(d[95:72]));
        dx = ex - sx;
        dy = ey - sy;
        adx = (dx < 0) ? -dx : dx;
        ady = (dy < 0) ? -dy : dy;
        root_len = int_root(adx * adx + ady * ady);
        n = longint'(root_len / (longint'(eff_step()) * 256)) + 1;
        ok = 1;
        for (i = 0; i < n && ok; i++) begin
          ok = mark_cell(sx + (i * dx) / n, sy + (i * dy) / n);
          if (ok && r.cells_marked != 10'd1023) r.cells_marked++;
        end
        if (ok) begin
          ok = mark_cell(ex, ey);
          if (ok && r.cells_marked != 10'd1023) r.cells_marked++;
        end
        r.status = !ok;
      end
      due.push_back(r);
    endfunction

    task check_result(logic [15:0] d);
      cell_result_t want;
      if (due.size() == 0) begin
        report("unexpected transfer", d, 0);
        return;
      end
      want = due.pop_front();
      if (d[0] !== want.status) report("status", d[0], want.status);
      if (d[1] !== want.cell_value) report("cell_value", d[1], want.cell_value);
      if (d[11:2] !== want.cells_marked) report("cells_marked", d[11:2], want.cells_marked);
    endtask
  endclass

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [111:0] s_axis_tdata = '0;
  logic         s_axis_tuser = 1'b0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [15:0]  m_axis_tdata;
  logic         cfg_valid = 1'b0;
  logic         cfg_ready;
  logic [2:0]   cfg_index = '0;
  logic [15:0]  cfg_data = '0;

  marker_scoreboard sb = new();
  int send_idle_pct = 0;
  int rx_stall_pct = 0;
  int hold_len = 0;
  int cycles = 0;

  grid_line_marker uut (.*);

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (hold_len > 0) begin
      m_axis_tready <= 1'b0;
      hold_len <= hold_len - 1;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
      if (s_axis_tvalid && s_axis_tready) sb.note_item(s_axis_tuser, s_axis_tdata);
      if (cfg_valid && cfg_ready) sb.set_reg(cfg_index, cfg_data);
    end
  end

  // leaves cfg_valid high; the caller lowers it after the batch
  task write_reg(logic [2:0] idx, logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task load_grid(logic [15:0] ox, logic [15:0] oy, logic [15:0] st,
                 logic [15:0] w, logic [15:0] h);
    write_reg(glm_pkg::REG_ORIGIN_X, ox);
    write_reg(glm_pkg::REG_ORIGIN_Y, oy);
    write_reg(glm_pkg::REG_CELL_STEP, st);
    write_reg(glm_pkg::REG_GRID_WIDTH, w);
    write_reg(glm_pkg::REG_GRID_HEIGHT, h);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task send_item(logic op, logic [23:0] sx, logic [23:0] sy, logic [23:0] ex,
                 logic [23:0] ey, logic [7:0] qc, logic [7:0] qr);
    if ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= op;
    s_axis_tdata <= {qr, qc, ey, ex, sy, sx};
    do @(posedge clk); while (!s_axis_tready);
  endtask

  task drain();
    s_axis_tvalid <= 1'b0;
    while (sb.due.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  function automatic logic [23:0] clamp_q(longint v);
    if (v > 8388607) v = 8388607;
    if (v < -8388608) v = -8388608;
    return v[23:0];
  endfunction

  // a point near the grid in Q16.8, mostly inside it
  function automatic longint grid_point(longint org, longint ext);
    longint st, slot, coord;
    st = sb.eff_step();
    slot = longint'($urandom_range(ext + 1)) - 1;
    coord = org + slot * st + $urandom_range(st - 1);
    if (coord > 32767) coord = 32767;
    if (coord < -32768) coord = -32768;
    return coord * 256 + $urandom_range(255);
  endfunction

  task random_item();
    longint sx, sy, span;
    int pick;
    pick = $urandom_range(99);
    if (pick < 25) begin
      if ($urandom_range(9) < 7)
        send_item(glm_pkg::OP_READ, 24'($urandom), 24'($urandom), 24'($urandom),
                  24'($urandom),
                  8'($urandom_range((sb.eff_w() > 0) ? sb.eff_w() - 1 : 0)),
                  8'($urandom_range((sb.eff_h() > 0) ? sb.eff_h() - 1 : 0)));
      else
        send_item(glm_pkg::OP_READ, 24'($urandom), 24'($urandom), 24'($urandom),
                  24'($urandom), 8'($urandom), 8'($urandom));
    end else if (pick < 88) begin
      sx = grid_point(sb.org_x, sb.eff_w());
      sy = grid_point(sb.org_y, sb.eff_h());
      span = longint'(sb.eff_step()) * 256 * $urandom_range(8);
      send_item(glm_pkg::OP_DRAW, clamp_q(sx), clamp_q(sy),
                clamp_q(sx + longint'($urandom_range(2 * span)) - span),
                clamp_q(sy + longint'($urandom_range(2 * span)) - span),
                8'($urandom), 8'($urandom));
    end else begin
      send_item(glm_pkg::OP_DRAW, 24'($urandom), 24'($urandom), 24'($urandom),
                24'($urandom), 8'($urandom), 8'($urandom));
    end
  endtask

  initial begin
    int ph;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    // register writes are taken during the clearing pass
    write_reg(REG_NONE, 16'hFFFF);
    load_grid(16'd0, 16'd0, 16'd1, 16'd256, 16'd256);

    send_item(glm_pkg::OP_READ, '0, '0, '0, '0, 8'd0, 8'd0);
    send_item(glm_pkg::OP_READ, '0, '0, '0, '0, 8'd255, 8'd255);
    send_item(glm_pkg::OP_DRAW, 24'd0, 24'd0, 24'd0, 24'd0, '0, '0);
    send_item(glm_pkg::OP_READ, '0, '0, '0, '0, 8'd0, 8'd0);
    send_item(glm_pkg::OP_DRAW, 24'd256, 24'd512, 24'd5000, 24'd3000, '0, '0);
    send_item(glm_pkg::OP_DRAW, 24'd256, 24'd256, 24'd256, 24'd256, '0, '0);
    send_item(glm_pkg::OP_DRAW, 24'd65280, 24'd65280, 24'd65535, 24'd65535, '0, '0);
    send_item(glm_pkg::OP_READ, '0, '0, '0, '0, 8'd255, 8'd255);
    // walks off the right edge: earlier cells stay marked
    send_item(glm_pkg::OP_DRAW, 24'd60000, 24'd100, 24'd80000, 24'd100, '0, '0);
    send_item(glm_pkg::OP_READ, '0, '0, '0, '0, 8'd240, 8'd0);
    // negative coordinates are off the grid
    send_item(glm_pkg::OP_DRAW, -24'sd300, 24'd100, 24'd100, 24'd100, '0, '0);
    send_item(glm_pkg::OP_DRAW, 24'd100, 24'd100, -24'sd600, 24'd100, '0, '0);
    send_item(glm_pkg::OP_DRAW, 24'h7FFFFF, 24'h7FFFFF, 24'h800000, 24'h800000,
              8'hFF, 8'hFF);
    send_item(glm_pkg::OP_DRAW, 24'h800000, 24'h800000, 24'h7FFFFF, 24'h7FFFFF, '0, '0);
    send_item(glm_pkg::OP_DRAW, 24'd2560, 24'd2560, 24'd2560, 24'd1280, '0, '0);
    send_item(glm_pkg::OP_READ, '0, '0, '0, '0, 8'd10, 8'd7);
    drain();

    // off-grid everywhere, zero step, clamp of an oversized height
    load_grid(16'h7FFF, 16'h8000, 16'd0, 16'd0, 16'd300);
    send_item(glm_pkg::OP_READ, '0, '0, '0, '0, 8'd0, 8'd0);
    send_item(glm_pkg::OP_DRAW, 24'd0, 24'd0, 24'd512, 24'd512, '0, '0);
    drain();
    load_grid(16'hFF9C, 16'd50, 16'd255, 16'd1, 16'd1);
    send_item(glm_pkg::OP_DRAW, -24'sd25600, 24'd12800, -24'sd25600, 24'd12800, '0, '0);
    send_item(glm_pkg::OP_READ, '0, '0, '0, '0, 8'd0, 8'd0);
    send_item(glm_pkg::OP_READ, '0, '0, '0, '0, 8'd1, 8'd0);
    drain();

    for (ph = 0; ph < 5; ph++) begin
      case (ph)
        0: load_grid(16'd0, 16'd0, 16'd1, 16'd256, 16'd256);
        1: load_grid(16'd1000, 16'hF830, 16'd7, 16'd40, 16'd511);
        2: load_grid(16'h8000, 16'h7FFF, 16'd3, 16'd256, 16'd100);
        3: load_grid(16'hFF9C, 16'd50, 16'd255, 16'd2, 16'd3);
        default: load_grid(16'd20, 16'd20, 16'd2, 16'd64, 16'd64);
      endcase
      send_idle_pct = (ph % 4 == 1) ? 62 : (ph % 4 == 3) ? 19 : 0;
      rx_stall_pct  = (ph % 4 == 2) ? 62 : (ph % 4 == 3) ? 19 : 0;
      if (ph == 1) hold_len = 3000;
      repeat (200) random_item();
      drain();
    end

    send_idle_pct = 0;
    rx_stall_pct = 0;
    s_axis_tvalid <= 1'b0;
    repeat (SETTLE) @(posedge clk);
    if (sb.errors == 0 && sb.due.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// File: grid_line_marker.f
hdl/glm_pkg.sv
hdl/glm_div.sv
hdl/grid_line_marker.sv
dv/tb.sv
